// ----- rtl/dwvp_pkg.sv -----
// ----------------------------------------------------------------------------
// dwvp_pkg
// types, register map and reset values shared by the dual wheel speed
// controller modules
// ----------------------------------------------------------------------------
package dwvp_pkg;

  // register indexes, byte address is 4 times the index
  localparam logic [2:0] REG_SETPOINT_LEFT  = 3'd0;
  localparam logic [2:0] REG_SETPOINT_RIGHT = 3'd1;
  localparam logic [2:0] REG_SPEED_SCALE    = 3'd2;
  localparam logic [2:0] REG_GAIN_P         = 3'd3;
  localparam logic [2:0] REG_GAIN_I         = 3'd4;
  localparam logic [2:0] REG_GAIN_D         = 3'd5;
  localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd6;

  localparam logic signed [23:0] RST_SETPOINT    = 24'sd5120;
  localparam logic        [23:0] RST_SPEED_SCALE = 24'd112951;
  localparam logic signed [15:0] RST_GAIN_P      = 16'sd2048;
  localparam logic signed [15:0] RST_GAIN_I      = 16'sd0;
  localparam logic signed [15:0] RST_GAIN_D      = 16'sd0;
  localparam logic        [9:0]  RST_DRIVE_LIMIT = 10'd500;

  typedef struct packed {
    logic signed [23:0] setpoint_left;
    logic signed [23:0] setpoint_right;
    logic        [23:0] speed_scale;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic        [9:0]  drive_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPEED,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_DRIVE,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SPEED,
    OP_ERR,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ACC,
    OP_DRIVE
  } op_e;

  typedef struct packed {
    logic capture;
    logic wheel;
    op_e  op;
    logic load_out;
  } cmd_t;

endpackage

// ----- rtl/dwvp_regs.sv -----
// ----------------------------------------------------------------------------
// dwvp_regs
// apb register file holding setpoints, speed scale, gains and drive limit
// ----------------------------------------------------------------------------
module dwvp_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output dwvp_pkg::cfg_t     cfg_o
);
  import dwvp_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint_left  <= RST_SETPOINT;
      cfg_q.setpoint_right <= RST_SETPOINT;
      cfg_q.speed_scale    <= RST_SPEED_SCALE;
      cfg_q.gain_p         <= RST_GAIN_P;
      cfg_q.gain_i         <= RST_GAIN_I;
      cfg_q.gain_d         <= RST_GAIN_D;
      cfg_q.drive_limit    <= RST_DRIVE_LIMIT;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_SETPOINT_LEFT:  cfg_q.setpoint_left  <= $signed(pwdata[23:0]);
        REG_SETPOINT_RIGHT: cfg_q.setpoint_right <= $signed(pwdata[23:0]);
        REG_SPEED_SCALE:    cfg_q.speed_scale    <= pwdata[23:0];
        REG_GAIN_P:         cfg_q.gain_p         <= $signed(pwdata[15:0]);
        REG_GAIN_I:         cfg_q.gain_i         <= $signed(pwdata[15:0]);
        REG_GAIN_D:         cfg_q.gain_d         <= $signed(pwdata[15:0]);
        REG_DRIVE_LIMIT:    cfg_q.drive_limit    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SETPOINT_LEFT:  prdata = {8'd0, cfg_q.setpoint_left};
      REG_SETPOINT_RIGHT: prdata = {8'd0, cfg_q.setpoint_right};
      REG_SPEED_SCALE:    prdata = {8'd0, cfg_q.speed_scale};
      REG_GAIN_P:         prdata = {16'd0, cfg_q.gain_p};
      REG_GAIN_I:         prdata = {16'd0, cfg_q.gain_i};
      REG_GAIN_D:         prdata = {16'd0, cfg_q.gain_d};
      REG_DRIVE_LIMIT:    prdata = {22'd0, cfg_q.drive_limit};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/dwvp_ctrl.sv -----
// ----------------------------------------------------------------------------
// dwvp_ctrl
// sequencer stepping both wheels through the shared multiplier
// ----------------------------------------------------------------------------
module dwvp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dwvp_pkg::cmd_t  cmd_o
);
  import dwvp_pkg::*;

  state_e state_q, state_d;
  logic   wheel_q, wheel_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    wheel_d = wheel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SPEED;
          wheel_d = 1'b0;
        end
      end
      ST_SPEED: state_d = ST_ERR;
      ST_ERR:   state_d = ST_MUL_P;
      ST_MUL_P: state_d = ST_MUL_I;
      ST_MUL_I: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_ACC;
      ST_ACC:   state_d = ST_DRIVE;
      ST_DRIVE: begin
        if (!wheel_q) begin
          state_d = ST_SPEED;
          wheel_d = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.wheel    = wheel_q;
    cmd_o.load_out = (state_q == ST_DONE) && slot_free;
    case (state_q)
      ST_SPEED: cmd_o.op = OP_SPEED;
      ST_ERR:   cmd_o.op = OP_ERR;
      ST_MUL_P: cmd_o.op = OP_MUL_P;
      ST_MUL_I: cmd_o.op = OP_MUL_I;
      ST_MUL_D: cmd_o.op = OP_MUL_D;
      ST_ACC:   cmd_o.op = OP_ACC;
      ST_DRIVE: cmd_o.op = OP_DRIVE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wheel_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wheel_q     <= wheel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_start_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SPEED && !wheel_q))
    else $error("accepted transfer did not start the left wheel");

  a_left_then_right : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRIVE && !wheel_q) |=> (state_q == ST_SPEED && wheel_q))
    else $error("right wheel did not follow the left wheel");

  a_load_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

endmodule

// ----- rtl/dwvp_datapath.sv -----
// ----------------------------------------------------------------------------
// dwvp_datapath
// per wheel pid arithmetic around one shared 33 x 17 signed multiplier
// ----------------------------------------------------------------------------
module dwvp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dwvp_pkg::cfg_t      cfg_i,
  input  dwvp_pkg::cmd_t      cmd_i,
  input  logic signed [15:0]  pulses_left_i,
  input  logic signed [15:0]  pulses_right_i,
  output logic signed [10:0]  drive_left_o,
  output logic signed [10:0]  drive_right_o
);
  import dwvp_pkg::*;

  logic               w;
  logic signed [15:0] pl_q, pr_q;
  logic signed [49:0] prod_q;
  logic signed [50:0] acc_q;
  logic signed [23:0] err_q;
  logic signed [24:0] diff_q;
  logic signed [23:0] last_err_q   [2];
  logic signed [31:0] esum_q       [2];
  logic signed [10:0] last_drive_q [2];
  logic signed [10:0] dout_l_q, dout_r_q;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [16:0] pulses_x;

  logic signed [41:0] speed_full;
  logic signed [23:0] speed;
  logic signed [23:0] setpoint;
  logic signed [24:0] err_full;
  logic signed [23:0] err_n;
  logic signed [24:0] diff_n;
  logic signed [32:0] esum_full;
  logic signed [31:0] esum_n;

  logic signed [50:0] rnd;
  logic signed [31:0] dsum;
  logic signed [31:0] lim;
  logic signed [31:0] drive_c;

  assign w        = cmd_i.wheel;
  assign pulses_x = w ? 17'(pr_q) : 17'(pl_q);

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.op)
      OP_SPEED: begin
        mul_a = $signed({9'd0, cfg_i.speed_scale});
        mul_b = pulses_x;
      end
      OP_MUL_P: begin
        mul_a = 33'(err_q);
        mul_b = 17'(cfg_i.gain_p);
      end
      OP_MUL_I: begin
        mul_a = 33'(esum_q[w]);
        mul_b = 17'(cfg_i.gain_i);
      end
      OP_MUL_D: begin
        mul_a = 33'(diff_q);
        mul_b = 17'(cfg_i.gain_d);
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 17'sd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // speed and error, saturating
  assign speed_full = $signed(prod_q[49:8]);
  always_comb begin
    if ((&speed_full[41:23]) || !(|speed_full[41:23])) begin
      speed = speed_full[23:0];
    end else begin
      speed = speed_full[41] ? 24'sh800000 : 24'sh7fffff;
    end
  end

  assign setpoint = w ? cfg_i.setpoint_right : cfg_i.setpoint_left;
  assign err_full = 25'(setpoint) - 25'(speed);

  always_comb begin
    if (err_full[24] == err_full[23]) begin
      err_n = err_full[23:0];
    end else begin
      err_n = err_full[24] ? 24'sh800000 : 24'sh7fffff;
    end
  end

  assign diff_n    = 25'(err_n) - 25'(last_err_q[w]);
  assign esum_full = 33'(esum_q[w]) + 33'(err_n);

  always_comb begin
    if (esum_full[32] == esum_full[31]) begin
      esum_n = esum_full[31:0];
    end else begin
      esum_n = esum_full[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
  end

  // round to nearest, add to last drive, clamp
  assign rnd  = acc_q + 51'sd524288;
  assign dsum = 32'(last_drive_q[w]) + 32'($signed(rnd[50:20]));
  assign lim  = $signed({22'd0, cfg_i.drive_limit});

  always_comb begin
    if (dsum > lim) begin
      drive_c = lim;
    end else if (dsum < -lim) begin
      drive_c = -lim;
    end else begin
      drive_c = dsum;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pl_q <= pulses_left_i;
      pr_q <= pulses_right_i;
    end
    case (cmd_i.op)
      OP_SPEED: prod_q <= mul_p;
      OP_ERR: begin
        err_q  <= err_n;
        diff_q <= diff_n;
      end
      OP_MUL_P: prod_q <= mul_p;
      OP_MUL_I: begin
        prod_q <= mul_p;
        acc_q  <= 51'(prod_q);
      end
      OP_MUL_D: begin
        prod_q <= mul_p;
        acc_q  <= acc_q + 51'(prod_q);
      end
      OP_ACC: acc_q <= acc_q + 51'(prod_q);
      default: ;
    endcase
    if (cmd_i.load_out) begin
      dout_l_q <= last_drive_q[0];
      dout_r_q <= last_drive_q[1];
    end
  end

  // controller state per wheel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q[0]   <= 24'sd0;
      last_err_q[1]   <= 24'sd0;
      esum_q[0]       <= 32'sd0;
      esum_q[1]       <= 32'sd0;
      last_drive_q[0] <= 11'sd0;
      last_drive_q[1] <= 11'sd0;
    end else begin
      case (cmd_i.op)
        OP_ERR: begin
          last_err_q[w] <= err_n;
          esum_q[w]     <= esum_n;
        end
        OP_DRIVE: last_drive_q[w] <= drive_c[10:0];
        default: ;
      endcase
    end
  end

  assign drive_left_o  = dout_l_q;
  assign drive_right_o = dout_r_q;

endmodule

// ----- rtl/dual_wheel_velocity_pid.sv -----
// ----------------------------------------------------------------------------
// dual_wheel_velocity_pid
// incremental pid speed controller for a two wheel drive
// ----------------------------------------------------------------------------
// Once per sample period a transfer brings the encoder pulse counts of both
// wheels. Each count is scaled to a speed in 1/256 cm/s (saturated to 24
// bits), the error against the wheel's setpoint feeds P, I and D terms with
// Q3.12 gains, and the rounded sum is added to the wheel's previous drive
// value and clamped to +/- drive_limit. One result transfer carries both new
// drive values. The next input is taken only once the previous item has left
// its load step: each wheel takes seven steps (speed product, error, the P, I
// and D products in series through the single 33 x 17 multiplier, accumulate,
// drive), left wheel first, then a load step writes the result register and
// the idle state takes the next input. The result sits in its own register,
// so the next input is accepted while a result still waits; a result that
// stays unread holds the following item in its load step until the register
// frees.
// Registers are written over apb at byte address 4 times the index.
// ----------------------------------------------------------------------------
module dual_wheel_velocity_pid (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] pulses_left, [31:16] pulses_right
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [10:0] drive_left, [21:11] drive_right, zeros
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dwvp_pkg::*;

  cfg_t               cfg;
  cmd_t               cmd;
  logic signed [10:0] drive_left;
  logic signed [10:0] drive_right;

  dwvp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: one item at a time, wheels in turn
  dwvp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // arithmetic, wheel state and result register
  dwvp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .pulses_left_i  ($signed(s_axis_tdata_i[15:0])),
    .pulses_right_i ($signed(s_axis_tdata_i[31:16])),
    .drive_left_o   (drive_left),
    .drive_right_o  (drive_right)
  );

  // pack both drives, pad to whole bytes
  assign m_axis_tdata_o = {2'b00, drive_right, drive_left};

endmodule
